// ===== hw/rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Item types, register indexes, status codes and the per-item step record
// shared between the decoder, the result sequencer and the top level.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned LEN_BITS = 16;

  typedef enum logic {
    REG_LENGTH_LIMIT = 1'b0,
    REG_LIMIT_ENABLE = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_RUNNING = 2'd0,
    STATUS_DONE    = 2'd1,
    STATUS_ERROR   = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
    logic       command;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          data_byte;
    logic                byte_valid;
    logic [1:0]          status;
    logic [LEN_BITS-1:0] decoded_length;
    logic                run_last;
  } out_item_t;

  typedef struct packed {
    logic [2:0][7:0]     bytes;
    logic [1:0]          num_bytes;
    logic [1:0]          num_results;
    logic [1:0]          status;
    logic [LEN_BITS-1:0] decoded_length;
  } step_t;

  typedef struct packed {
    logic [LEN_BITS-1:0] length_limit;
    logic                limit_enable;
  } cfg_t;

endpackage

// ===== hw/rtl/json_string_unescaper.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper
// Decodes one JSON string from a byte stream into UTF-8 bytes.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while the input is not stalled and
// answers each with one to three result items; a byte whose work ends in a
// single item (plain characters, whitespace, escape prefixes, hex digits) lets
// the next byte in as soon as that item is taken. The first result item of a
// byte is offered in the cycle after the byte is accepted. A \u escape that
// ends in a two- or three-byte UTF-8 sequence holds the input while the result
// register hands out its items one per cycle when the result side does not
// stall. A byte that runs into the length limit adds one trailing item without
// data. A stall on the result side holds the current item and the input. The
// result stage is a single record register, so the input is stalled exactly
// while that record still has items left after the current cycle. Decoded
// lengths count saturating at 2**COUNT_BITS-1 and are shown capped at 65535.
module json_string_unescaper #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jsu_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output jsu_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import jsu_pkg::*;

  cfg_t  cfg_r;
  step_t step;
  logic  accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.length_limit <= 16'd256;
      cfg_r.limit_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_LENGTH_LIMIT: cfg_r.length_limit <= cfg_wdata;
        REG_LIMIT_ENABLE: cfg_r.limit_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  jsu_decode #(
    .COUNT_BITS(COUNT_BITS)
  ) u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .item  (in_item),
    .cfg   (cfg_r),
    .step  (step)
  );

  jsu_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .step     (step),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

// ===== hw/rtl/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper decoder
// Holds the parse state and works out, for one input item, the decoded
// bytes, the length check and the status, updating state on acceptance.
// ----------------------------------------------------------------------------
module jsu_decode #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  jsu_pkg::in_item_t item,
  input  jsu_pkg::cfg_t   cfg,
  output jsu_pkg::step_t  step
);
  import jsu_pkg::*;

  localparam int unsigned W = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 2;

  typedef enum logic [2:0] {
    PH_SEEK = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3,
    PH_DONE = 3'd4,
    PH_ERR  = 3'd5
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [1:0]            hex_r, hex_nxt;
  logic [15:0]           cp_r, cp_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  phase_t          ph;
  logic [1:0]      hs;
  logic [15:0]     cpr;
  logic [15:0]     cp;
  logic [W-1:0]    bcw;
  logic [W-1:0]    maxw;
  logic [W-1:0]    limw;
  logic [W-1:0]    cnt [3];
  logic [W-1:0]    new_cnt;
  logic [2:0]      ok;
  logic [1:0]      nc;
  logic [1:0]      na;
  logic [2:0][7:0] cand;
  logic            fin;
  logic            hex_ok;
  logic [3:0]      hex_d;
  logic            overflow;
  phase_t          ph_end;
  logic [7:0]      ch;

  assign ch = item.text_byte;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      hex_d = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      hex_d = ch[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    ph      = item.command ? PH_SEEK : phase_r;
    hs      = item.command ? 2'd0 : hex_r;
    cpr     = item.command ? 16'd0 : cp_r;
    bcw     = item.command ? '0 : W'(count_r);
    fin     = item.final_byte;
    nc      = 2'd0;
    cand    = '0;
    cp      = {cpr[11:0], hex_d};
    hex_nxt = hs;
    cp_nxt  = cpr;
    phase_nxt = ph;
    unique case (ph)
      PH_DONE, PH_ERR: begin
        fin = 1'b0;
      end
      PH_SEEK: begin
        if (ch == 8'h22) begin
          phase_nxt = PH_STR;
        end else if (!(ch == 8'h20 || ch == 8'h09 || ch == 8'h0A || ch == 8'h0D)) begin
          phase_nxt = PH_ERR;
        end
      end
      PH_STR: begin
        if (ch == 8'h22) begin
          phase_nxt = PH_DONE;
        end else if (ch < 8'h20) begin
          phase_nxt = PH_ERR;
        end else if (ch == 8'h5C) begin
          phase_nxt = PH_ESC;
        end else begin
          cand[0] = ch;
          nc      = 2'd1;
        end
      end
      PH_ESC: begin
        phase_nxt = PH_STR;
        nc        = 2'd1;
        unique case (ch)
          8'h22, 8'h5C, 8'h2F: cand[0] = ch;
          8'h62: cand[0] = 8'h08;
          8'h66: cand[0] = 8'h0C;
          8'h6E: cand[0] = 8'h0A;
          8'h72: cand[0] = 8'h0D;
          8'h74: cand[0] = 8'h09;
          8'h75: begin
            phase_nxt = PH_HEX;
            hex_nxt   = 2'd0;
            cp_nxt    = 16'd0;
            nc        = 2'd0;
          end
          default: begin
            phase_nxt = PH_ERR;
            nc        = 2'd0;
          end
        endcase
      end
      PH_HEX: begin
        if (!hex_ok) begin
          phase_nxt = PH_ERR;
        end else if (hs != 2'd3) begin
          hex_nxt = hs + 2'd1;
          cp_nxt  = cp;
        end else begin
          hex_nxt   = 2'd0;
          cp_nxt    = 16'd0;
          phase_nxt = PH_STR;
          if (cp >= 16'hD800 && cp <= 16'hDFFF) begin
            phase_nxt = PH_ERR;
          end else if (cp < 16'h0080) begin
            cand[0] = cp[7:0];
            nc      = 2'd1;
          end else if (cp < 16'h0800) begin
            cand[0] = 8'hC0 | {3'd0, cp[10:6]};
            cand[1] = 8'h80 | {2'd0, cp[5:0]};
            nc      = 2'd2;
          end else begin
            cand[0] = 8'hE0 | {4'd0, cp[15:12]};
            cand[1] = 8'h80 | {2'd0, cp[11:6]};
            cand[2] = 8'h80 | {2'd0, cp[5:0]};
            nc      = 2'd3;
          end
        end
      end
      default: begin
        phase_nxt = PH_ERR;
      end
    endcase
  end

  always_comb begin
    maxw = W'({COUNT_BITS{1'b1}});
    limw = W'(cfg.length_limit);
    for (int k = 0; k < 3; k++) begin
      cnt[k] = ((bcw + W'(k)) > maxw) ? maxw : (bcw + W'(k));
      ok[k]  = !cfg.limit_enable || (cnt[k] < limw);
    end
    if (nc >= 2'd1 && ok[0]) begin
      if (nc >= 2'd2 && ok[1]) begin
        na = (nc == 2'd3 && ok[2]) ? 2'd3 : 2'd2;
      end else begin
        na = 2'd1;
      end
    end else begin
      na = 2'd0;
    end
    overflow = (na != nc);
    new_cnt  = ((bcw + W'(na)) > maxw) ? maxw : (bcw + W'(na));
    ph_end   = overflow ? PH_ERR : phase_nxt;
    if (fin && ph_end != PH_DONE) begin
      ph_end = PH_ERR;
    end
    count_nxt = new_cnt[COUNT_BITS-1:0];

    step.bytes          = cand;
    step.num_bytes      = na;
    step.num_results    = na + 2'((overflow || na == 2'd0) ? 1 : 0);
    step.status         = (ph_end == PH_DONE) ? STATUS_DONE :
                          (ph_end == PH_ERR)  ? STATUS_ERROR : STATUS_RUNNING;
    step.decoded_length = (new_cnt > W'(16'hFFFF)) ? 16'hFFFF : new_cnt[LEN_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      hex_r   <= 2'd0;
      cp_r    <= 16'd0;
      count_r <= '0;
    end else if (accept) begin
      phase_r <= ph_end;
      hex_r   <= hex_nxt;
      cp_r    <= cp_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/jsu_out.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper result sequencer
// Registers the record of one step and hands out its one to three result
// items in order, taking the next record as the last item leaves.
// ----------------------------------------------------------------------------
module jsu_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jsu_pkg::step_t     step,
  output logic               out_valid,
  input  logic               out_stall,
  output jsu_pkg::out_item_t out_item
);
  import jsu_pkg::*;

  step_t      rec_r;
  logic       full_r;
  logic [1:0] idx_r;
  logic       take;
  logic       last;

  assign out_valid = full_r;
  assign take      = full_r && !out_stall;
  assign last      = (idx_r == rec_r.num_results - 2'd1);
  assign in_stall  = full_r && !(take && last);

  always_comb begin
    out_item.byte_valid     = (idx_r < rec_r.num_bytes);
    out_item.data_byte      = out_item.byte_valid ? rec_r.bytes[idx_r] : 8'd0;
    out_item.status         = rec_r.status;
    out_item.decoded_length = rec_r.decoded_length;
    out_item.run_last       = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (in_valid && !in_stall) begin
      full_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (take) begin
      if (last) begin
        full_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      rec_r <= step;
    end
  end

endmodule

// ===== hw/rtl/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper port checker
// Watches the top-level ports for result ordering and field consistency.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input jsu_pkg::out_item_t out_item
);
  import jsu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.byte_valid |-> out_item.data_byte == 8'd0 && out_item.run_last)
    else $error("result without data is not the clean last item of its run");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status == STATUS_RUNNING || out_item.status == STATUS_DONE ||
                  out_item.status == STATUS_ERROR)
    else $error("unknown status code");

  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.run_last |-> in_stall)
    else $error("input taken while a run still has items to give");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result item");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);
